// File: rtl/assert_macros.svh
// Assertion macros shared by the framer RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MRF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define MRF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Invariant that holds at every edge out of reset
`define MRF_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
        else $error("assertion failed: invariant");

`endif

// File: rtl/mrf_pkg.sv
// Package for the Modbus RTU receive framer: widths, event codes, structs.
// No dependencies; used by every other RTL file but assert_macros.svh.
package mrf_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 9;
    localparam int CRC_W       = 16;
    localparam int TICK_W      = 16;
    localparam int EVENT_W     = 3;
    localparam int REG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam int BUFFER_BYTES_DEFAULT = 256;

    localparam logic [CRC_W-1:0]  CRC_INIT        = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY        = 16'hA001;
    localparam logic [BYTE_W-1:0] ADDR_RESET      = 8'hFF;
    localparam logic [BYTE_W-1:0] ADDR_BROADCAST  = 8'h00;
    localparam logic [BYTE_W-1:0] SLAVE_ADDR_RST  = 8'd1;
    localparam logic [TICK_W-1:0] TIMEOUT_RST     = 16'd1000;
    localparam logic [TICK_W-1:0] SILENCE_MAX     = 16'hFFFF;
    localparam int                MIN_FRAME_BYTES = 3;

    // Configuration register indexes
    localparam logic [REG_INDEX_W-1:0] REG_SLAVE_ADDRESS = 8'd0;
    localparam logic [REG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;

    // Item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_STORED    = 3'd0,
        EV_OURS      = 3'd1,
        EV_BROADCAST = 3'd2,
        EV_OTHER     = 3'd3,
        EV_FULL      = 3'd4,
        EV_TIMEOUT   = 3'd5,
        EV_IDLE      = 3'd6
    } mrf_event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] slave_address;
        logic [TICK_W-1:0] timeout_ticks;
    } mrf_cfg_t;

    typedef struct packed {
        mrf_event_t        event_res;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] function_code;
    } mrf_result_t;

endpackage

// File: rtl/mrf_stream_if.sv
// Valid/ready channel interfaces for the framer: input word, result word, config write.
// Depends on mrf_pkg for field widths.
interface mrf_in_if
    import mrf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mrf_out_if
    import mrf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic [LEN_W-1:0]   frame_length;
    logic [BYTE_W-1:0]  function_code;

    modport source (output valid, output event_res, output byte_index, output byte_value,
                    output frame_length, output function_code, input ready);
    modport sink   (input valid, input event_res, input byte_index, input byte_value,
                    input frame_length, input function_code, output ready);
endinterface

interface mrf_cfg_if
    import mrf_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [REG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/mrf_crc8.sv
// Bytewise Modbus CRC-16 fold (reflected polynomial, LSB first), combinational.
// Depends on mrf_pkg.
module mrf_crc8
    import mrf_pkg::*;
(
    input  logic [CRC_W-1:0]  crc,
    input  logic [BYTE_W-1:0] data,
    output logic [CRC_W-1:0]  crc_new
);

    // Eight shift/xor steps on the running remainder
    always_comb
    begin
        logic [CRC_W-1:0] acc;
        acc = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        crc_new = acc;
    end

endmodule

// File: rtl/mrf_frame_core.sv
// Frame state (CRC, count, silence, header bytes) and per-word event decode.
// Depends on mrf_pkg, mrf_crc8 and assert_macros.svh.
`include "assert_macros.svh"

module mrf_frame_core
    import mrf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              cmd,
    input  logic [BYTE_W-1:0] rx_byte,
    input  mrf_cfg_t          cfg,
    output mrf_result_t       result
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(MIN_FRAME_BYTES);

    logic [CRC_W-1:0]  crc_reg, crc_next, crc_fold;
    logic [CNT_W-1:0]  count_reg, count_next, count_inc;
    logic [TICK_W-1:0] silence_reg, silence_next, silence_inc;
    logic [BYTE_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] func_reg, func_next;
    logic              restart;

    mrf_crc8 u_crc (
        .crc     (crc_reg),
        .data    (rx_byte),
        .crc_new (crc_fold)
    );

    assign count_inc   = count_reg + 1'b1;
    assign silence_inc = (silence_reg == SILENCE_MAX) ? silence_reg : silence_reg + 1'b1;

    // Event decode and next frame state
    always_comb
    begin
        crc_next     = crc_reg;
        count_next   = count_reg;
        silence_next = silence_reg;
        addr_next    = addr_reg;
        func_next    = func_reg;
        restart      = 1'b0;
        result       = '0;
        result.event_res = EV_IDLE;
        if (cmd == CMD_BYTE)
        begin
            if (count_reg >= CNT_FULL)
            begin
                result.event_res = EV_FULL;
            end
            else
            begin
                result.byte_index = BYTE_W'(count_reg);
                result.byte_value = rx_byte;
                result.event_res  = EV_STORED;
                if (count_reg == '0)
                    addr_next = rx_byte;
                else if (count_reg == CNT_W'(1))
                    func_next = rx_byte;
                count_next   = count_inc;
                silence_next = '0;
                crc_next     = crc_fold;
                // CRC residue of zero closes the frame once it holds more than MIN_FRAME_BYTES bytes
                if (crc_fold == '0 && count_inc > CNT_MIN)
                begin
                    restart = 1'b1;
                    if (addr_reg == ADDR_BROADCAST)
                        result.event_res = EV_BROADCAST;
                    else if (addr_reg == cfg.slave_address)
                        result.event_res = EV_OURS;
                    else
                        result.event_res = EV_OTHER;
                    if (result.event_res != EV_OTHER)
                    begin
                        result.frame_length  = LEN_W'(count_inc);
                        result.function_code = func_reg;
                    end
                end
            end
        end
        else if (count_reg != '0)
        begin
            silence_next = silence_inc;
            if (silence_inc >= cfg.timeout_ticks)
            begin
                restart          = 1'b1;
                result.event_res = EV_TIMEOUT;
            end
        end
        if (restart)
        begin
            crc_next     = CRC_INIT;
            count_next   = '0;
            silence_next = '0;
            addr_next    = ADDR_RESET;
            func_next    = '0;
        end
    end

    // Frame state registers, updated when a word moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            count_reg   <= '0;
            silence_reg <= '0;
            addr_reg    <= ADDR_RESET;
            func_reg    <= '0;
        end
        else if (step)
        begin
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            silence_reg <= silence_next;
            addr_reg    <= addr_next;
            func_reg    <= func_next;
        end
    end

    // Checks
    `MRF_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_FULL)
    `MRF_ASSERT_NEXT(a_restart_clears, clk, rst_n, step && restart,
        count_reg == '0 && crc_reg == CRC_INIT && silence_reg == '0)
    `MRF_ASSERT_NEXT(a_full_holds, clk, rst_n, step && result.event_res == EV_FULL,
        count_reg == CNT_FULL && crc_reg == $past(crc_reg))

endmodule

// File: rtl/modbus_rtu_rx_framer.sv
// Modbus RTU receive framer: input register, frame core, result register.
// An accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle unless the result side stalls; combinational CRC fold.
// Reset: CRC 0xFFFF, empty frame, slave address 1, timeout 1000 ticks, both stages empty.
// Depends on mrf_pkg, the mrf_stream_if interfaces, mrf_frame_core, assert_macros.svh.
`include "assert_macros.svh"

module modbus_rtu_rx_framer
    import mrf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    mrf_in_if.sink   byte_ch,
    mrf_out_if.source event_ch,
    mrf_cfg_if.sink  cfg_ch
);

    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    mrf_result_t       out_reg;
    mrf_result_t       core_result;
    mrf_cfg_t          cfg_reg;
    logic              advance;

    // A held word moves on when the result slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || event_ch.ready);
    assign byte_ch.ready = !in_valid_reg || advance;
    assign cfg_ch.ready  = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address <= SLAVE_ADDR_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.reg_index)
                REG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_ch.wdata[BYTE_W-1:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_ch.wdata[TICK_W-1:0];
                default:           ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_ch.ready)
            in_valid_reg <= byte_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            in_cmd_reg  <= byte_ch.cmd;
            in_byte_reg <= byte_ch.rx_byte;
        end
    end

    mrf_frame_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .cmd     (in_cmd_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Result register
    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (event_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= core_result;
    end

    assign event_ch.valid         = out_valid_reg;
    assign event_ch.event_res     = out_reg.event_res;
    assign event_ch.byte_index    = out_reg.byte_index;
    assign event_ch.byte_value    = out_reg.byte_value;
    assign event_ch.frame_length  = out_reg.frame_length;
    assign event_ch.function_code = out_reg.function_code;

    // Checks
    `MRF_ASSERT_NEXT(a_held_word_kept, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_cmd_reg))
    `MRF_ASSERT_IMPL(a_len_on_accept, clk, rst_n, out_valid_reg,
        (out_reg.frame_length != '0) ==
        (out_reg.event_res == EV_OURS || out_reg.event_res == EV_BROADCAST))
    `MRF_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance, out_valid_reg)

endmodule

// File: tb/modbus_rtu_rx_framer_test.sv
// Self-checking testbench for the Modbus RTU receive framer.
// A class model predicts every event word; driver tasks feed frames, ticks and register writes.
// Depends on mrf_pkg, the mrf_stream_if interfaces and the modbus_rtu_rx_framer RTL.
`timescale 1ns / 1ps

module modbus_rtu_rx_framer_test;
    import mrf_pkg::*;

    localparam int  BUF_BYTES     = 256;
    localparam int  HALF_PERIOD   = 10;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  PHASE_WORDS   = 230;
    localparam int  STALL_PCT     = 28;
    localparam int  REPORT_LIMIT  = 10;
    localparam real LIMIT_NS      = 10_000_000.0;

    // Register index the block does not decode
    localparam logic [REG_INDEX_W-1:0] REG_UNMAPPED = 8'd2;

    typedef enum int {FRAME_GOOD, FRAME_FLIPPED, FRAME_TRUNCATED} frame_shape_t;

    // Framer model: own copy of configuration and frame state, plus expected event words
    class rtu_frame_model;
        int                buffer_bytes;
        logic [BYTE_W-1:0] slave_address;
        logic [TICK_W-1:0] timeout_ticks;
        logic [CRC_W-1:0]  running_crc;
        logic [LEN_W-1:0]  byte_count;
        logic [TICK_W-1:0] silence_count;
        logic [BYTE_W-1:0] frame_address;
        logic [BYTE_W-1:0] function_byte;
        mrf_result_t       expected_events[$];
        int                mismatches;

        function new(int depth);
            buffer_bytes  = depth;
            slave_address = SLAVE_ADDR_RST;
            timeout_ticks = TIMEOUT_RST;
            mismatches    = 0;
            restart();
        endfunction

        static function logic [CRC_W-1:0] fold_crc(logic [CRC_W-1:0] crc,
                                                   logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] c;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void restart();
            running_crc   = CRC_INIT;
            byte_count    = '0;
            silence_count = '0;
            frame_address = ADDR_RESET;
            function_byte = '0;
        endfunction

        function void apply_register(logic [REG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            if (index == REG_SLAVE_ADDRESS)
                slave_address = value[BYTE_W-1:0];
            else if (index == REG_TIMEOUT_TICKS)
                timeout_ticks = value[TICK_W-1:0];
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        // Predict the event word for one accepted input word
        function void note_word(logic cmd, logic [BYTE_W-1:0] b);
            mrf_result_t r;
            r = '0;
            if (cmd == CMD_BYTE)
            begin
                if (byte_count >= buffer_bytes)
                    r.event_res = EV_FULL;
                else
                begin
                    r.event_res  = EV_STORED;
                    r.byte_index = byte_count[BYTE_W-1:0];
                    r.byte_value = b;
                    if (byte_count == 0)
                        frame_address = b;
                    else if (byte_count == 1)
                        function_byte = b;
                    byte_count    = byte_count + 1'b1;
                    silence_count = '0;
                    running_crc   = fold_crc(running_crc, b);
                    // CRC residue of zero closes the frame once it holds more than MIN_FRAME_BYTES bytes
                    if (running_crc == '0 && byte_count > MIN_FRAME_BYTES)
                    begin
                        if (frame_address == ADDR_BROADCAST)
                            r.event_res = EV_BROADCAST;
                        else if (frame_address == slave_address)
                            r.event_res = EV_OURS;
                        else
                            r.event_res = EV_OTHER;
                        if (r.event_res != EV_OTHER)
                        begin
                            r.frame_length  = byte_count;
                            r.function_code = function_byte;
                        end
                        restart();
                    end
                end
            end
            else
            begin
                r.event_res = EV_IDLE;
                if (byte_count != 0)
                begin
                    if (silence_count != SILENCE_MAX)
                        silence_count = silence_count + 1'b1;
                    if (silence_count >= timeout_ticks)
                    begin
                        restart();
                        r.event_res = EV_TIMEOUT;
                    end
                end
            end
            expected_events.push_back(r);
        endfunction

        function void flag(string what, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        endfunction

        // Compare one received event word with the oldest prediction
        function void check_event(mrf_result_t got);
            mrf_result_t want;
            if (expected_events.size() == 0)
            begin
                flag("unexpected event word", '0, got.event_res);
                return;
            end
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res)
                flag("event_res", want.event_res, got.event_res);
            if (got.byte_index !== want.byte_index)
                flag("byte_index", want.byte_index, got.byte_index);
            if (got.byte_value !== want.byte_value)
                flag("byte_value", want.byte_value, got.byte_value);
            if (got.frame_length !== want.frame_length)
                flag("frame_length", want.frame_length, got.frame_length);
            if (got.function_code !== want.function_code)
                flag("function_code", want.function_code, got.function_code);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   stall_on;
    int   words_sent;

    rtu_frame_model framer_model;

    mrf_in_if  byte_ch ();
    mrf_out_if event_ch ();
    mrf_cfg_if cfg_ch ();

    modbus_rtu_rx_framer #(
        .BUFFER_BYTES (BUF_BYTES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .event_ch (event_ch),
        .cfg_ch   (cfg_ch)
    );

    // Clock
    always #HALF_PERIOD clk = ~clk;

    // Run limit
    initial
    begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        event_ch.ready <= !stall_on || ($urandom_range(99) >= STALL_PCT);
    end

    // Handshake monitor: register writes, accepted words, event words
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                framer_model.apply_register(cfg_ch.reg_index, cfg_ch.wdata);
            if (byte_ch.valid && byte_ch.ready)
                framer_model.note_word(byte_ch.cmd, byte_ch.rx_byte);
            if (event_ch.valid && event_ch.ready)
                framer_model.check_event(mrf_result_t'({event_ch.event_res,
                    event_ch.byte_index, event_ch.byte_value,
                    event_ch.frame_length, event_ch.function_code}));
        end
    end

    // Drive one input word; called and returns at a falling edge
    task automatic send_word(input logic c, input logic [BYTE_W-1:0] b);
        while (stall_on && $urandom_range(99) < STALL_PCT)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.cmd     <= c;
        byte_ch.rx_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, 8'($urandom_range(255)));
    endtask

    // Enough silence to close any open frame under the given timeout
    task automatic flush_ticks(input logic [TICK_W-1:0] timeout);
        repeat (int'(timeout) + 1)
            send_tick();
    endtask

    // Frame with CRC appended low byte first; optional ticks between bytes
    task automatic send_frame(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] fc,
                              input int payload_len, input frame_shape_t shape,
                              input int max_gap);
        logic [BYTE_W-1:0] body[$];
        logic [CRC_W-1:0]  crc;
        body.push_back(addr);
        body.push_back(fc);
        repeat (payload_len)
            body.push_back(8'($urandom_range(255)));
        crc = CRC_INIT;
        foreach (body[i])
            crc = rtu_frame_model::fold_crc(crc, body[i]);
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        if (shape == FRAME_FLIPPED)
            body[$urandom_range(body.size() - 1)] ^= 8'(1 << $urandom_range(7));
        else if (shape == FRAME_TRUNCATED)
            repeat ($urandom_range(1, 2))
                void'(body.pop_back());
        foreach (body[i])
        begin
            if (max_gap > 0 && $urandom_range(99) < 20)
                repeat ($urandom_range(1, max_gap))
                    send_tick();
            send_word(CMD_BYTE, body[i]);
        end
    endtask

    task automatic write_register(input logic [REG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= index;
        cfg_ch.wdata     <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop feeding and wait until every predicted word has come out
    task automatic settle_idle();
        byte_ch.valid <= 1'b0;
        while (framer_model.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // One configuration setting followed by random traffic
    task automatic run_phase(input logic [BYTE_W-1:0] slave, input logic [TICK_W-1:0] timeout,
                             input int words, input bit with_overflow);
        int                start;
        int                pick;
        int                sel;
        int                len;
        int                gap;
        logic [BYTE_W-1:0] addr;
        settle_idle();
        write_register(REG_SLAVE_ADDRESS, CFG_DATA_W'(slave));
        write_register(REG_TIMEOUT_TICKS, CFG_DATA_W'(timeout));
        start = words_sent;
        gap   = (timeout > 32) ? 5 : ((timeout > 1) ? int'(timeout) - 1 : 0);
        // Overrun the buffer, then let the timeout end the frame
        if (with_overflow)
        begin
            repeat ($urandom_range(258, 262))
                send_word(CMD_BYTE, 8'($urandom_range(255)));
            flush_ticks(timeout);
        end
        while (words_sent - start < words)
        begin
            pick = $urandom_range(99);
            sel  = $urandom_range(9);
            addr = (sel < 5) ? slave : ((sel < 7) ? ADDR_BROADCAST : 8'($urandom_range(255)));
            len  = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            if (timeout > 32)
            begin
                // Long timeout: broken frames would never close, keep them well formed
                if (pick < 85)
                    send_frame(addr, 8'($urandom_range(255)), len, FRAME_GOOD, gap);
                else
                    repeat ($urandom_range(1, 4))
                        send_tick();
            end
            else if (pick < 65)
                send_frame(addr, 8'($urandom_range(255)), len, FRAME_GOOD, gap);
            else if (pick < 85)
            begin
                send_frame(addr, 8'($urandom_range(255)), len,
                           $urandom_range(1) ? FRAME_FLIPPED : FRAME_TRUNCATED, gap);
                flush_ticks(timeout);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
                flush_ticks(timeout);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        framer_model     = new(BUF_BYTES);
        stall_on         = 1'b1;
        words_sent       = 0;
        rst_n            = 1'b0;
        byte_ch.valid    = 1'b0;
        byte_ch.cmd      = CMD_BYTE;
        byte_ch.rx_byte  = '0;
        event_ch.ready   = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wdata     = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: idle tick, own, broadcast and foreign frames
        send_word(CMD_TICK, 8'hFF);
        send_frame(SLAVE_ADDR_RST, 8'hFF, 0, FRAME_GOOD, 0);
        send_frame(ADDR_BROADCAST, 8'h00, 1, FRAME_GOOD, 0);
        send_frame(8'hFF, 8'h10, 0, FRAME_GOOD, 0);

        // Zero timeout: first tick in an open frame restarts
        settle_idle();
        write_register(REG_SLAVE_ADDRESS, CFG_DATA_W'(ADDR_BROADCAST));
        write_register(REG_TIMEOUT_TICKS, 16'd0);
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_BYTE, 8'hFF);
        send_tick();
        // Slave address zero: frame to zero still counts as broadcast
        send_frame(ADDR_BROADCAST, 8'h2B, 0, FRAME_GOOD, 0);

        // Silence counting below and at the timeout; unmapped register is ignored
        settle_idle();
        write_register(REG_TIMEOUT_TICKS, 16'd3);
        write_register(REG_UNMAPPED, 16'hFFFF);
        send_word(CMD_BYTE, 8'h5A);
        repeat (3)
            send_tick();

        // Random phases over several settings
        run_phase(8'd247, 16'd1, PHASE_WORDS, 1'b0);
        run_phase(SLAVE_ADDR_RST, 16'hFFFF, PHASE_WORDS, 1'b0);
        run_phase(8'($urandom_range(2, 246)), 16'($urandom_range(2, 12)), PHASE_WORDS, 1'b1);
        run_phase(ADDR_BROADCAST, 16'd0, PHASE_WORDS, 1'b0);
        stall_on = 1'b0;
        run_phase(8'($urandom_range(1, 247)), TIMEOUT_RST, PHASE_WORDS, 1'b0);
        stall_on = 1'b1;
        run_phase(8'($urandom_range(1, 247)), 16'($urandom_range(1, 20)), PHASE_WORDS, 1'b1);

        settle_idle();
        if (framer_model.mismatches == 0 && framer_model.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: modbus_rtu_rx_framer.f
+incdir+rtl
rtl/mrf_pkg.sv
rtl/mrf_stream_if.sv
rtl/mrf_crc8.sv
rtl/mrf_frame_core.sv
rtl/modbus_rtu_rx_framer.sv
tb/modbus_rtu_rx_framer_test.sv
